// ===== rtl/core/spd_pkg.sv =====
package spd_pkg;

  // configuration port widths
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_OFFSET     = 8'd0,
    REG_GAIN_SLOPE      = 8'd1,
    REG_DERIVATIVE_GAIN = 8'd2,
    REG_SERVO_MIDPOINT  = 8'd3
  } spd_reg_e;

  // register reset values
  localparam logic [CFG_DAT_W-1:0] GAIN_OFFSET_RST     = 16'd256;
  localparam logic [CFG_DAT_W-1:0] GAIN_SLOPE_RST      = 16'd0;
  localparam logic [CFG_DAT_W-1:0] DERIVATIVE_GAIN_RST = 16'd0;
  localparam logic [CFG_DAT_W-1:0] SERVO_MIDPOINT_RST  = 16'd1500;

  // current register contents
  typedef struct packed {
    logic [CFG_DAT_W-1:0] gain_offset;
    logic [CFG_DAT_W-1:0] gain_slope;
    logic [CFG_DAT_W-1:0] derivative_gain;
    logic [CFG_DAT_W-1:0] servo_midpoint;
  } spd_cfg_t;

  // one operation for the shared multiply-accumulate unit
  typedef struct packed {
    logic                 valid;
    logic                 accum;   // add to running sum rather than to addend
    logic [CFG_DAT_W-1:0] addend;
  } spd_mac_ctl_t;

endpackage

// ===== rtl/core/spd_if.sv =====
// column request channel
interface spd_col_if;
  logic       valid;
  logic       ready;
  logic [8:0] center_column;

  modport source (output valid, output center_column, input ready);
  modport sink   (input valid, input center_column, output ready);
endinterface

// drive result channel
interface spd_drive_if;
  logic               valid;
  logic               ready;
  logic [15:0]        servo_drive;
  logic [23:0]        turn_gain;
  logic signed [8:0]  limited_error;

  modport source (output valid, output servo_drive, output turn_gain,
                  output limited_error, input ready);
  modport sink   (input valid, input servo_drive, input turn_gain,
                  input limited_error, output ready);
endinterface

// configuration write channel
interface spd_cfg_if;
  import spd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/spd_cfg_regs.sv =====
module spd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  spd_cfg_if.sink           cfg_i,
  output spd_pkg::spd_cfg_t cfg_o
);
  import spd_pkg::*;

  spd_cfg_t regs_q, regs_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register decoder, unknown indexes dropped
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (spd_reg_e'(cfg_i.index))
        REG_GAIN_OFFSET:     regs_d.gain_offset     = cfg_i.data;
        REG_GAIN_SLOPE:      regs_d.gain_slope      = cfg_i.data;
        REG_DERIVATIVE_GAIN: regs_d.derivative_gain = cfg_i.data;
        REG_SERVO_MIDPOINT:  regs_d.servo_midpoint  = cfg_i.data;
        default:             regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.gain_offset     <= GAIN_OFFSET_RST;
      regs_q.gain_slope      <= GAIN_SLOPE_RST;
      regs_q.derivative_gain <= DERIVATIVE_GAIN_RST;
      regs_q.servo_midpoint  <= SERVO_MIDPOINT_RST;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

// ===== rtl/core/spd_mac.sv =====
module spd_mac #(
  parameter int unsigned AW = 11,
  parameter int unsigned BW = 25,
  parameter int unsigned SW = 37
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spd_pkg::spd_mac_ctl_t ctl_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic [BW-1:0]         b_i,
  output logic signed [SW-1:0]  acc_o
);
  import spd_pkg::*;

  localparam int unsigned PW = AW + BW;

  spd_mac_ctl_t         ctl_q;
  logic signed [BW:0]   b_s;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [SW-1:0] base;
  logic signed [SW-1:0] acc_d, acc_q;

  // stage one: signed times unsigned product
  assign b_s    = $signed({1'b0, b_i});
  assign prod_d = PW'(a_i * b_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // stage two: add to addend or to running sum
  assign base  = ctl_q.accum ? acc_q : $signed(SW'(ctl_q.addend));
  assign acc_d = base + SW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/steering_pd_slew_limited.sv =====
// channel   role    payload                                       handshake
// col_i     sink    center_column                                 valid/ready
// drive_o   source  servo_drive, turn_gain, limited_error         valid/ready
// cfg_i     sink    index, data                                   valid/ready
//
// a request is taken in the idle state; then the error is clipped, three
// products go through the single two-stage multiply-accumulate unit (gain,
// with a wait for it, then proportional and derivative), the sum is rounded,
// and the midpoint is added as the result is loaded before returning to idle
// the column input is ready only while idle; a result waiting in the output
// register does not hold off the next request, only a second finished one
// reset (async, active low) clears the sequencer, the stored previous error
// and the registers to their default values
module steering_pd_slew_limited #(
  parameter int unsigned IMAGE_WIDTH    = 320,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spd_col_if.sink    col_i,
  spd_drive_if.source drive_o,
  spd_cfg_if.sink    cfg_i
);
  import spd_pkg::*;

  // derived constants and widths
  localparam int unsigned HALF_WIDTH = IMAGE_WIDTH / 2;
  localparam int unsigned SLEW_STEP  = IMAGE_WIDTH / 10;
  localparam int unsigned COL_MAX    = IMAGE_WIDTH - 1;
  localparam int unsigned COL_W      = $clog2(IMAGE_WIDTH);
  localparam int unsigned ERR_W      = COL_W + 1;
  localparam int unsigned DW         = ERR_W + 1;
  localparam int unsigned MW         = COL_W;
  localparam int unsigned GW         = MW + 17;
  localparam int unsigned SW         = DW + GW + 1;
  localparam int unsigned LW         = (COL_W > 9) ? COL_W : 9;

  localparam logic signed [ERR_W-1:0] HALF_S   = ERR_W'(HALF_WIDTH);
  localparam logic signed [DW-1:0]    SLEW_S   = DW'(SLEW_STEP);
  localparam logic signed [DW-1:0]    SLEW_NEG = -SLEW_S;
  localparam logic signed [SW-1:0]    RND_BIAS =
    SW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LIMIT = 9'b000000010,
    S_MUL_G = 9'b000000100,
    S_WAIT_G = 9'b000001000,
    S_MUL_P = 9'b000010000,
    S_MUL_D = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_ROUND = 9'b010000000,
    S_DRIVE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  spd_cfg_t cfg;

  logic [LW-1:0]           col_l;
  logic [COL_W-1:0]        col_sat;
  logic [COL_W-1:0]        col_q;
  logic signed [ERR_W-1:0] prev_q;
  logic signed [ERR_W-1:0] err_raw, err_lim, err_q;
  logic signed [DW-1:0]    prev_ext, delta_raw, lim_sum, delta_lim, delta_q;
  logic [MW-1:0]           mag, mag_q;
  logic [GW-1:0]           gain_q;
  logic [15:0]             corr_q;

  spd_mac_ctl_t            mac_ctl;
  logic signed [DW-1:0]    mac_a;
  logic [GW-1:0]           mac_b;
  logic signed [SW-1:0]    mac_acc;
  logic signed [SW-1:0]    round_add, biased, shifted;

  logic                    out_valid_q;
  logic [15:0]             out_drive_q;
  logic [23:0]             out_gain_q;
  logic signed [8:0]       out_err_q;
  logic                    load_out;

  spd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  spd_mac #(
    .AW (DW),
    .BW (GW),
    .SW (SW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  // column saturated to the image
  assign col_l   = LW'(col_i.center_column);
  assign col_sat = (col_l > LW'(COL_MAX)) ? COL_W'(COL_MAX) : COL_W'(col_l);

  // error and slew clip against previous error
  always_comb begin
    err_raw   = $signed({1'b0, col_q}) - HALF_S;
    prev_ext  = DW'(prev_q);
    delta_raw = DW'(err_raw) - prev_ext;
    lim_sum   = DW'(err_raw);
    if (delta_raw > SLEW_S) begin
      lim_sum = prev_ext + SLEW_S;
    end else if (delta_raw < SLEW_NEG) begin
      lim_sum = prev_ext - SLEW_S;
    end
    err_lim   = ERR_W'(lim_sum);
    delta_lim = lim_sum - prev_ext;
    mag       = err_lim[ERR_W-1] ? MW'(-err_lim) : MW'(err_lim);
  end

  // operand selection for the shared unit
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_q)
      S_MUL_G: begin
        mac_ctl.valid  = 1'b1;
        mac_ctl.addend = cfg.gain_offset;
        mac_a          = DW'({1'b0, mag_q});
        mac_b          = GW'(cfg.gain_slope);
      end
      S_MUL_P: begin
        mac_ctl.valid = 1'b1;
        mac_a         = DW'(err_q);
        mac_b         = mac_acc[GW-1:0];
      end
      S_MUL_D: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = delta_q;
        mac_b         = GW'(cfg.derivative_gain);
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // divide by the fraction, truncating toward zero
  assign round_add = mac_acc[SW-1] ? RND_BIAS : '0;
  assign biased    = mac_acc + round_add;
  assign shifted   = biased >>> GAIN_FRAC_BITS;

  assign load_out = (state_q == S_DRIVE) && (!out_valid_q || drive_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (col_i.valid) state_d = S_LIMIT;
      S_LIMIT:  state_d = S_MUL_G;
      S_MUL_G:  state_d = S_WAIT_G;
      S_WAIT_G: state_d = S_MUL_P;
      S_MUL_P:  state_d = S_MUL_D;
      S_MUL_D:  state_d = S_SUM;
      S_SUM:    state_d = S_ROUND;
      S_ROUND:  state_d = S_DRIVE;
      S_DRIVE:  if (load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LIMIT) begin
        prev_q <= err_lim;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && col_i.valid) begin
      col_q <= col_sat;
    end
    if (state_q == S_LIMIT) begin
      err_q   <= err_lim;
      delta_q <= delta_lim;
      mag_q   <= mag;
    end
    if (state_q == S_MUL_P) begin
      gain_q <= mac_acc[GW-1:0];
    end
    if (state_q == S_ROUND) begin
      corr_q <= shifted[15:0];
    end
  end

  assign col_i.ready = (state_q == S_IDLE);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (drive_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_drive_q <= cfg.servo_midpoint + corr_q;
      out_gain_q  <= 24'(gain_q);
      out_err_q   <= 9'(err_q);
    end
  end

  assign drive_o.valid         = out_valid_q;
  assign drive_o.servo_drive   = out_drive_q;
  assign drive_o.turn_gain     = out_gain_q;
  assign drive_o.limited_error = out_err_q;

`ifndef SYNTHESIS
  // an accepted request starts the error clip next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_i.valid && col_i.ready) |=> (state_q == S_LIMIT))
    else $error("request accepted without starting the sequence");

  // the stored error change never exceeds the slew step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_D) |-> (delta_q <= SLEW_S && delta_q >= SLEW_NEG))
    else $error("error change beyond slew step");

  // a new result appears only from the final sequencer step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DRIVE))
    else $error("result raised outside the drive step");

  // the shared unit is idle by the time the sum is rounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> ($past(state_q) == S_SUM && !mac_ctl.valid))
    else $error("rounding while the multiply-accumulate is busy");
`endif

endmodule
